### rtl/asp_pkg.sv
// ---------------------------------------------------------------------------
// asp_pkg
// Types, register indexes and the confidence mode table shared by the
// adaptive sequential prefetcher files.
// ---------------------------------------------------------------------------
package asp_pkg;

   localparam int unsigned ADDR_W      = 64;
   localparam int unsigned TID_W       = 8;
   localparam int unsigned SHIFT_W     = 4;
   localparam int unsigned DEPTH_W     = 6;
   localparam int unsigned EXTRA_W     = 5;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 6;
   localparam int unsigned REQ_DATA_W  = 72;
   localparam int unsigned RSP_DATA_W  = 80;

   localparam logic [DEPTH_W-1:0] DEPTH_CAP = 6'd32;

   localparam logic [SHIFT_W-1:0] LINE_SHIFT_RESET   = 4'd6;
   localparam logic [DEPTH_W-1:0] BASE_DEPTH_RESET   = 6'd9;
   localparam logic [EXTRA_W-1:0] STEADY_EXTRA_RESET = 5'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_SHIFT   = 2'd0,
      CSR_BASE_DEPTH   = 2'd1,
      CSR_STEADY_EXTRA = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_INIT       = 2'd0,
      MODE_STEADY     = 2'd1,
      MODE_TRANSIENT  = 2'd2,
      MODE_NO_PREDICT = 2'd3
   } mode_type;

   typedef enum logic {
      SEQ_IDLE = 1'b0,
      SEQ_RUN  = 1'b1
   } seq_state_type;

   // Control from the sequencer to the address unit.
   typedef struct packed {
      logic load;
      logic step;
   } addr_ctrl_type;

   function automatic mode_type next_mode(input mode_type mode, input logic hit);
      mode_type result;
      result = mode;
      if (hit) begin
         unique case (mode)
            MODE_INIT:       result = MODE_NO_PREDICT;
            MODE_STEADY:     result = MODE_TRANSIENT;
            MODE_TRANSIENT:  result = MODE_INIT;
            MODE_NO_PREDICT: result = MODE_NO_PREDICT;
         endcase
      end else begin
         unique case (mode)
            MODE_INIT:       result = MODE_TRANSIENT;
            MODE_STEADY:     result = MODE_STEADY;
            MODE_TRANSIENT:  result = MODE_STEADY;
            MODE_NO_PREDICT: result = MODE_INIT;
         endcase
      end
      return result;
   endfunction

endpackage

### rtl/adaptive_sequential_prefetcher_core.sv
// ---------------------------------------------------------------------------
// adaptive_sequential_prefetcher_core
// Turns each cache access beat into a run of sequential line prefetches.
// ---------------------------------------------------------------------------
// An event beat is taken only while idle, after which the block issues its
// prefetch run through a single 64-bit stride adder, one line per cycle while
// the response side is ready. No new event is taken until the run's last
// line is issued, and an empty run never leaves the idle state;
// the depth is base_depth capped at 32, plus steady_extra on a miss seen in
// the steady mode. The last response beat of a run may still be waiting in
// the output register while the next event is taken.
module adaptive_sequential_prefetcher_core
   import asp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Event channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // access_address, thread_id
   input  logic                  req_tuser,  // func: 0 miss, 1 hit
   // Prefetch channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // prefetch_address, prefetch_thread,
                                             // reported_count, zero pad
   output logic                  rsp_tlast,
   // Register writes.
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [SHIFT_W-1:0] line_shift_ff;
   logic [DEPTH_W-1:0] base_depth_ff;
   logic [EXTRA_W-1:0] steady_extra_ff;

   seq_state_type      state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [DEPTH_W-1:0] count_ff, count_in;
   logic [DEPTH_W-1:0] base_ff, base_in;
   logic [TID_W-1:0]   tid_ff, tid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [TID_W-1:0]   rsp_tid_ff, rsp_tid_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [DEPTH_W-1:0] rsp_count_ff, rsp_count_in;

   addr_ctrl_type      addr_ctrl;
   logic [ADDR_W-1:0]  next_addr;

   logic               accept;
   logic               hit;
   logic [DEPTH_W-1:0] base_eff;
   logic [DEPTH_W-1:0] run_depth;
   logic               step;
   logic               final_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_shift_ff   <= LINE_SHIFT_RESET;
         base_depth_ff   <= BASE_DEPTH_RESET;
         steady_extra_ff <= STEADY_EXTRA_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LINE_SHIFT:   line_shift_ff   <= csr_wdata[SHIFT_W-1:0];
            CSR_BASE_DEPTH:   base_depth_ff   <= csr_wdata;
            CSR_STEADY_EXTRA: steady_extra_ff <= csr_wdata[EXTRA_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == SEQ_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign hit        = req_tuser;
   assign base_eff   = (base_depth_ff > DEPTH_CAP) ? DEPTH_CAP : base_depth_ff;
   // Capped base is at most 32 and the extra at most 31, so the sum fits.
   assign run_depth  = (!hit && mode_ff == MODE_STEADY)
                     ? base_eff + {1'b0, steady_extra_ff} : base_eff;

   assign step       = (state_ff == SEQ_RUN) && (!rsp_valid_ff || rsp_tready);
   assign final_step = step && (count_ff == depth_ff);

   assign addr_ctrl.load = accept;
   assign addr_ctrl.step = step;

   asp_addr_unit u_addr (
      .clock      (clock),
      .ctrl       (addr_ctrl),
      .load_addr  (req_tdata[ADDR_W-1:0]),
      .load_shift (line_shift_ff),
      .next_addr  (next_addr)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      base_in      = base_ff;
      tid_in       = tid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_tid_in   = rsp_tid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               mode_in  = next_mode(mode_ff, hit);
               depth_in = run_depth;
               count_in = {{(DEPTH_W-1){1'b0}}, 1'b1};
               base_in  = base_eff;
               tid_in   = req_tdata[ADDR_W +: TID_W];
               // An empty run updates the mode and issues nothing.
               if (run_depth != '0) begin
                  state_in = SEQ_RUN;
               end
            end
         end
         SEQ_RUN: begin
            if (step) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = next_addr;
               rsp_tid_in   = tid_ff;
               rsp_last_in  = final_step;
               rsp_count_in = final_step ? base_ff : '0;
               count_in     = count_ff + 1'b1;
               if (final_step) begin
                  state_in = SEQ_IDLE;
               end
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         mode_ff      <= MODE_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      depth_ff     <= depth_in;
      count_ff     <= count_in;
      base_ff      <= base_in;
      tid_ff       <= tid_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_tid_ff   <= rsp_tid_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-ADDR_W-TID_W-DEPTH_W){1'b0}},
                        rsp_count_ff, rsp_tid_ff, rsp_addr_ff};

   // A nonempty run always starts the sequencer.
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && run_depth != '0) |=> (state_ff == SEQ_RUN))
      else $error("nonempty event did not start a run");

   // The beat count never passes the run length while running.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_RUN) |-> (count_ff != '0 && count_ff <= depth_ff))
      else $error("run beat count out of range");

   // The final step returns to idle with a last beat pending.
   a_final_ends: assert property (@(posedge clock) disable iff (reset)
      final_step |=> (state_ff == SEQ_IDLE && rsp_tvalid && rsp_tlast))
      else $error("run did not end on its final beat");

   // Only the last beat of a run carries a count.
   a_count_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_count_ff == '0))
      else $error("count reported on a beat that is not last");

endmodule

### rtl/asp_addr_unit.sv
// ---------------------------------------------------------------------------
// asp_addr_unit
// Running line address: one 64-bit adder that adds the line stride to the
// held address on every step of a prefetch run.
// ---------------------------------------------------------------------------
module asp_addr_unit
   import asp_pkg::*;
(
   input  logic              clock,
   input  addr_ctrl_type     ctrl,
   input  logic [ADDR_W-1:0] load_addr,
   input  logic [SHIFT_W-1:0] load_shift,
   output logic [ADDR_W-1:0] next_addr
);

   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] stride_ff, stride_in;

   assign next_addr = addr_ff + stride_ff;

   always_comb begin
      addr_in   = addr_ff;
      stride_in = stride_ff;
      priority if (ctrl.load) begin
         addr_in   = load_addr;
         stride_in = {{(ADDR_W-1){1'b0}}, 1'b1} << load_shift;
      end else if (ctrl.step) begin
         addr_in = next_addr;
      end else begin
         addr_in = addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      stride_ff <= stride_in;
   end

endmodule

### tb/tb_adaptive_sequential_prefetcher_core.sv
// ---------------------------------------------------------------------------
// tb_adaptive_sequential_prefetcher_core
// Self-checking testbench for the adaptive sequential prefetcher core. It
// sends cache miss and hit events under several register settings and
// predicts the prefetch run of every accepted event from a confidence mode
// tracked beside the block. Each returned prefetch beat is checked field by
// field against the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module tb_adaptive_sequential_prefetcher_core
   import asp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic EV_MISS = 1'b0;
   localparam logic EV_HIT  = 1'b1;

   // Index past the end of the register list; writes to it must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_EVENTS  = 50;

   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [TID_W-1:0]   tid;
      logic               last;
      logic [DEPTH_W-1:0] count;
   } prefetch_beat_type;

   class prefetch_tracker_type;
      logic [SHIFT_W-1:0] line_shift;
      logic [DEPTH_W-1:0] base_depth;
      logic [EXTRA_W-1:0] steady_extra;
      mode_type           mode;
      prefetch_beat_type  expected_prefetches[$];
      int                 mismatch_count;

      function new();
         line_shift     = LINE_SHIFT_RESET;
         base_depth     = BASE_DEPTH_RESET;
         steady_extra   = STEADY_EXTRA_RESET;
         mode           = MODE_INIT;
         mismatch_count = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_LINE_SHIFT:   line_shift   = val[SHIFT_W-1:0];
            CSR_BASE_DEPTH:   base_depth   = val[DEPTH_W-1:0];
            CSR_STEADY_EXTRA: steady_extra = val[EXTRA_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_event(logic hit, logic [ADDR_W-1:0] addr, logic [TID_W-1:0] tid);
         logic [DEPTH_W-1:0] base;
         logic [ADDR_W-1:0]  stride;
         logic [ADDR_W-1:0]  line_addr;
         int                 run;
         prefetch_beat_type  beat;
         base = (base_depth > DEPTH_CAP) ? DEPTH_CAP : base_depth;
         run  = base;
         // The run length comes from the mode held before this event.
         if (!hit && mode == MODE_STEADY) begin
            run = base + steady_extra;
         end
         stride    = 64'd1 << line_shift;
         line_addr = addr;
         for (int k = 1; k <= run; k++) begin
            line_addr  = line_addr + stride;
            beat.addr  = line_addr;
            beat.tid   = tid;
            beat.last  = (k == run);
            beat.count = (k == run) ? base : '0;
            expected_prefetches.push_back(beat);
         end
         case (mode)
            MODE_INIT:      mode = hit ? MODE_NO_PREDICT : MODE_TRANSIENT;
            MODE_STEADY:    mode = hit ? MODE_TRANSIENT  : MODE_STEADY;
            MODE_TRANSIENT: mode = hit ? MODE_INIT       : MODE_STEADY;
            default:        mode = hit ? MODE_NO_PREDICT : MODE_INIT;
         endcase
      endfunction

      function int pending();
         return expected_prefetches.size();
      endfunction

      function void check_prefetch(logic [ADDR_W-1:0] addr, logic [TID_W-1:0] tid,
                                   logic last, logic [DEPTH_W-1:0] count, logic [1:0] pad);
         prefetch_beat_type want;
         if (expected_prefetches.size() == 0) begin
            $error("unexpected prefetch beat: address %h thread %h", addr, tid);
            mismatch_count++;
            return;
         end
         want = expected_prefetches.pop_front();
         if (addr !== want.addr) begin
            $error("prefetch_address: expected %h, got %h", want.addr, addr);
            mismatch_count++;
         end
         if (tid !== want.tid) begin
            $error("prefetch_thread: expected %h, got %h", want.tid, tid);
            mismatch_count++;
         end
         if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            mismatch_count++;
         end
         if (count !== want.count) begin
            $error("reported_count: expected %0d, got %0d", want.count, count);
            mismatch_count++;
         end
         if (pad !== 2'b00) begin
            $error("tdata pad: expected 0, got %b", pad);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   prefetch_tracker_type tracker = new();

   int cycles       = 0;
   int burst_left   = 0;
   int stall_pct    = 0;
   int stretch_left = 0;

   adaptive_sequential_prefetcher_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("adaptive_sequential_prefetcher_core test failed");
         $finish;
      end
   end

   // All three ports are sampled here with their values from before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            tracker.write_reg(csr_index, csr_wdata);
         end
         if (req_tvalid && req_tready) begin
            tracker.note_event(req_tuser, req_tdata[ADDR_W-1:0],
                               req_tdata[ADDR_W+TID_W-1:ADDR_W]);
         end
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_prefetch(rsp_tdata[ADDR_W-1:0], rsp_tdata[ADDR_W+TID_W-1:ADDR_W],
                                   rsp_tlast, rsp_tdata[ADDR_W+TID_W+DEPTH_W-1:ADDR_W+TID_W],
                                   rsp_tdata[RSP_DATA_W-1:ADDR_W+TID_W+DEPTH_W]);
         end
      end
   end

   // The receiver moves between stretches of different stall rates,
   // including stretches where it never stalls.
   always @(posedge clock) begin
      if (stretch_left == 0) begin
         case ($urandom_range(0, 4))
            0, 1:    stall_pct <= 0;
            2:       stall_pct <= 25;
            3:       stall_pct <= 60;
            default: stall_pct <= 85;
         endcase
         stretch_left <= $urandom_range(30, 300);
      end else begin
         stretch_left <= stretch_left - 1;
      end
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Presents one event beat and returns after the edge that takes it.
   // Valid stays high unless the burst ends and a gap is inserted.
   task automatic issue(input logic kind, input logic [ADDR_W-1:0] addr,
                        input logic [TID_W-1:0] tid);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {tid, addr};
      do @(posedge clock); while (req_tready !== 1'b1);
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 8);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Holds off the sender until every predicted prefetch has come back,
   // then lets any empty run that is still in flight finish.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Writes all three registers, then a write to the unused index.
   task automatic set_regs(input logic [CSR_DATA_W-1:0] shift_w,
                           input logic [CSR_DATA_W-1:0] depth_w,
                           input logic [CSR_DATA_W-1:0] extra_w);
      write_csr(CSR_LINE_SHIFT, shift_w);
      write_csr(CSR_BASE_DEPTH, depth_w);
      write_csr(CSR_STEADY_EXTRA, extra_w);
      write_csr(CSR_SPARE, CSR_DATA_W'($urandom_range(0, 63)));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [ADDR_W-1:0] pick_address();
      logic [ADDR_W-1:0] a;
      a = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0:       a[ADDR_W-1:16] = '1;
         1:       a[ADDR_W-1:16] = '0;
         default: ;
      endcase
      return a;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_depth();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CSR_DATA_W'($urandom_range(32, 63));
         default: return CSR_DATA_W'($urandom_range(1, 12));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_extra();
      logic [CSR_DATA_W-1:0] e;
      case ($urandom_range(0, 9))
         0:       e = 6'd31;
         1:       e = 6'd0;
         default: e = CSR_DATA_W'($urandom_range(0, 8));
      endcase
      // The upper bit lies outside the register and must be dropped.
      e[CSR_DATA_W-1] = 1'($urandom_range(0, 1));
      return e;
   endfunction

   initial begin
      int               sent;
      int               run_len;
      logic             kind;
      logic [TID_W-1:0] tid;
      bit               paused;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: walk every mode transition, starting from init.
      issue(EV_MISS, 64'h0, 8'h00);
      issue(EV_MISS, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
      issue(EV_MISS, 64'hAAAA_AAAA_AAAA_AAAA, 8'hAA);
      issue(EV_HIT, 64'h5555_5555_5555_5555, 8'h55);
      issue(EV_HIT, 64'h0000_0000_0000_0040, 8'h01);
      issue(EV_HIT, 64'hFFFF_FFFF_FFFF_FFC0, 8'h80);
      issue(EV_HIT, 64'h8000_0000_0000_0000, 8'h7F);
      issue(EV_MISS, 64'h7FFF_FFFF_FFFF_FFFF, 8'hFE);

      // Largest legal run: full depth plus full steady extra.
      drain_block();
      set_regs(6'd12, 6'd32, 6'd31);
      issue(EV_MISS, 64'h0123_4567_89AB_CDEF, 8'h11);
      issue(EV_MISS, 64'hFEDC_BA98_7654_3210, 8'h22);
      issue(EV_MISS, 64'hFFFF_FFFF_FFFF_F000, 8'h33);
      issue(EV_HIT, 64'hFFFF_FFFF_FFFF_FFFF, 8'h44);

      // Depth above range saturates; shift 15 with the high write bits set.
      drain_block();
      set_regs(6'h3F, 6'd63, 6'h3F);
      issue(EV_MISS, 64'hFFFF_FFFF_FFF0_0000, 8'h5A);
      issue(EV_MISS, 64'hFFFF_FFFF_FFFF_FFFF, 8'hA5);
      issue(EV_HIT, 64'h0000_0000_0000_0001, 8'h3C);

      // Zero depth: no prefetches at all, the mode still moves.
      drain_block();
      set_regs(6'd0, 6'd0, 6'd0);
      issue(EV_MISS, 64'h0000_0000_0000_0000, 8'hC3);
      issue(EV_MISS, 64'hFFFF_FFFF_FFFF_FFFF, 8'h0F);
      issue(EV_HIT, 64'h1234_5678_9ABC_DEF0, 8'hF0);

      // Zero depth with steady extra: only the steady miss prefetches.
      drain_block();
      set_regs(6'd0, 6'd0, 6'd5);
      issue(EV_MISS, 64'hFFFF_FFFF_FFFF_FFFD, 8'h66);
      issue(EV_MISS, 64'hFFFF_FFFF_FFFF_FFFE, 8'h99);

      drain_block();
      set_regs(6'd0, 6'd1, 6'd0);
      issue(EV_MISS, 64'hFFFF_FFFF_FFFF_FFFF, 8'h77);
      issue(EV_HIT, 64'h0000_0000_0000_0000, 8'h88);

      paused = 1'b0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_block();
         case (phase)
            0:       set_regs(CSR_DATA_W'($urandom_range(0, 63)), 6'd63, 6'd31);
            1:       set_regs(CSR_DATA_W'($urandom_range(0, 63)), 6'd0, pick_extra());
            default: set_regs(CSR_DATA_W'($urandom_range(0, 63)), pick_depth(), pick_extra());
         endcase
         sent = 0;
         while (sent < PHASE_EVENTS) begin
            // Events come in runs of one kind so the mode reaches every state.
            run_len = $urandom_range(1, 5);
            kind    = ($urandom_range(0, 99) < 60) ? EV_MISS : EV_HIT;
            tid     = TID_W'($urandom_range(0, 255));
            for (int j = 0; j < run_len && sent < PHASE_EVENTS; j++) begin
               if ($urandom_range(0, 3) == 0) begin
                  tid = TID_W'($urandom_range(0, 255));
               end
               issue(kind, pick_address(), tid);
               sent++;
            end
            if (phase == 3 && !paused && sent >= PHASE_EVENTS / 2) begin
               drain_block();
               paused = 1'b1;
            end
         end
      end

      drain_block();
      if (tracker.mismatch_count == 0) begin
         $display("adaptive_sequential_prefetcher_core test passed");
      end else begin
         $display("adaptive_sequential_prefetcher_core test failed");
      end
      $finish;
   end

endmodule
